// ===== sv/rsh_pkg.sv =====
// Package for the running statistics block with histogram.
// Holds operation codes, bin status codes and shared widths; no dependencies.
package rsh_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 64;
  localparam int unsigned IdxW  = 10;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  localparam logic [1:0] BIN_NONE  = 2'd0;
  localparam logic [1:0] BIN_UPDT  = 2'd1;
  localparam logic [1:0] BIN_RANGE = 2'd2;

  localparam logic [1:0] CFG_SCALE  = 2'd0;
  localparam logic [1:0] CFG_BINW   = 2'd1;
  localparam logic [1:0] CFG_HALWAY = 2'd2;

  typedef struct packed {
    logic start;
    logic busy;
  } rsh_ctl_t;
endpackage

// ===== sv/rsh_divsqrt.sv =====
// Shared multi-cycle unit: restoring 64/32 unsigned divide, or 64-bit integer sqrt.
// Depends on rsh_pkg. One quotient bit or one root bit per cycle.
module rsh_divsqrt
  import rsh_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             sqrt_i,
  input  logic [WideW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [WideW-1:0] res_o
);
  logic [WideW-1:0] num_q, num_d, res_q, res_d, bit_q, bit_d;
  logic [WideW:0]   rem_q, rem_d, trial;
  logic [6:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, sq_q, sq_d, done_d, done_q;

  always_comb begin
    num_d  = num_q;
    res_d  = res_q;
    bit_d  = bit_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sq_d   = sq_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      busy_d = 1'b1;
      sq_d   = sqrt_i;
      num_d  = num_i;
      rem_d  = '0;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
      cnt_d  = sqrt_i ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (sq_q) begin
        // num_q holds the shrinking radicand
        trial = {1'b0, res_q} + {1'b0, bit_q};
        if ({1'b0, num_q} >= trial) begin
          num_d = num_q - trial[WideW-1:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        trial = {rem_q[WideW-1:0], num_q[WideW-1]};
        num_d = {num_q[WideW-2:0], 1'b0};
        if (trial >= {33'd0, den_i}) begin
          rem_d = trial - {33'd0, den_i};
          res_d = {res_q[WideW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          res_d = {res_q[WideW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sq_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sq_q   <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    res_q <= res_d;
    bit_q <= bit_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;
endmodule

// ===== sv/running_stats_histogram.sv =====
// Running statistics (count, min, max, mean, std dev) with a histogram RAM.
// Depends on rsh_pkg and rsh_divsqrt.
// An add beat passes through scale multiply, bin divide, bin read-modify-write,
// sum divide, sum-of-squares divide, sqrt and output; the sqrt is skipped when
// the variance is not positive.
// One item at a time: new beats stall while a beat or a clear sweep is in
// progress; a clear beat returns its result, then sweeps the whole RAM.
// Reset sweeps the whole histogram RAM with input stalled.
module running_stats_histogram
  import rsh_pkg::*;
#(
  parameter int unsigned HIST_BINS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic signed [31:0] sample_i,
  input  logic              hist_this_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       sample_count_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] max_value_o,
  output logic signed [31:0] mean_value_o,
  output logic [31:0]       std_dev_o,
  output logic [9:0]        bin_index_o,
  output logic [31:0]       bin_total_o,
  output logic [1:0]        bin_status_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  localparam int unsigned AW = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_ACC, S_BDIV, S_BRD, S_BWR, S_MDIV, S_QDIV,
    S_SQRT, S_OUT
  } state_e;

  state_e state_q;
  logic [31:0] scale_q;
  logic [15:0] binw_q;
  logic        halw_q;

  logic [31:0] cnt_q;
  logic signed [31:0] min_q, max_q, x_q, mean_q;
  logic signed [63:0] sum_q;
  logic [63:0] sq_q, ex2_q;
  logic [AW-1:0] clr_q;
  logic        hist_q;
  logic        clr_go_q;

  logic [31:0] hist_mem [HIST_BINS];
  logic [31:0] rd_q;
  logic [AW-1:0] bidx_q;
  logic [31:0] bq_q, br_q;
  logic [5:0]  bc_q;
  logic [31:0] std_q, btot_q;

  logic [31:0] o_cnt_q, o_std_q, o_btot_q;
  logic signed [31:0] o_min_q, o_max_q, o_mean_q;
  logic [9:0]  o_bidx_q;
  logic [1:0]  o_bst_q, bst_q;
  logic        ov_q;
  logic        out_load;

  logic [31:0] mag_q;
  logic        neg_q;
  logic [63:0] prod_q;

  rsh_ctl_t    ctl;
  logic        ds_q;
  logic        ds_sqrt;
  logic [63:0] ds_num, ds_res;
  logic        ds_done;
  logic [63:0] sq_x, msq;
  logic signed [64:0] sum_w;
  logic [64:0] sq_w;
  logic [63:0] magsum;
  logic [32:0] btrial;
  logic [15:0] w_eff;
  logic [63:0] qsel;
  logic        qneg;
  logic signed [31:0] mean_sat;

  assign w_eff = (binw_q == 16'd0) ? 16'd1 : binw_q;
  assign sq_x  = 64'($signed(x_q) * $signed(x_q));
  assign sum_w = 65'(sum_q) + 65'(x_q);
  assign sq_w  = {1'b0, sq_q} + {1'b0, sq_x};
  assign magsum = sum_q[63] ? (64'd0 - sum_q) : sum_q;
  assign msq   = 64'($signed(mean_q) * $signed(mean_q));
  assign btrial = {bq_q, br_q[31]} >= 33'(w_eff) ? 33'd0 : 33'd0;
  assign qneg  = sum_q[63];
  assign qsel  = ds_res;
  assign mean_sat = qneg ? ((qsel >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(qsel[31:0]))
                         : ((qsel > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qsel[31:0]));

  assign ctl.busy = (state_q != S_IDLE);
  assign ctl.start = (state_q == S_MDIV && !ds_q) || (state_q == S_QDIV && !ds_q) ||
                     (state_q == S_SQRT && !ds_q);
  assign ds_sqrt = (state_q == S_SQRT);
  assign ds_num  = (state_q == S_MDIV) ? magsum :
                   (state_q == S_QDIV) ? sq_q : ex2_q - msq;

  rsh_divsqrt u_ds (
    .clk_i, .rst_ni, .start_i(ctl.start), .sqrt_i(ds_sqrt), .num_i(ds_num),
    .den_i(cnt_q), .done_o(ds_done), .res_o(ds_res)
  );

  assign in_stall_o = (state_q != S_IDLE);
  // load the output beat once the previous one has left
  assign out_load   = (state_q == S_OUT) && (!ov_q || !out_stall_i);

  // histogram RAM: one write port, one registered read
  logic        mwe;
  logic [AW-1:0] maddr;
  logic [31:0] mwd;
  always_comb begin
    mwe = 1'b0; maddr = bidx_q; mwd = '0;
    if (state_q == S_CLR) begin
      mwe = 1'b1; maddr = clr_q;
    end else if (state_q == S_BWR && bst_q == BIN_UPDT) begin
      mwe = 1'b1; mwd = (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mwe) hist_mem[maddr] <= mwd;
    rd_q <= hist_mem[maddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      neg_q <= sample_i[31];
      mag_q <= sample_i[31] ? 32'(-sample_i) : sample_i;
    end
    if (state_q == S_MUL) prod_q <= 64'(mag_q) * 64'(scale_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      scale_q <= 32'd65536; binw_q <= 16'd1; halw_q <= 1'b0;
      cnt_q <= '0; min_q <= '0; max_q <= '0; sum_q <= '0; sq_q <= '0;
      ov_q <= 1'b0; ds_q <= 1'b0; hist_q <= 1'b0; x_q <= '0; mean_q <= '0;
      ex2_q <= '0; bidx_q <= '0; bq_q <= '0; br_q <= '0; bc_q <= '0;
      bst_q <= BIN_NONE; std_q <= '0; btot_q <= '0; clr_go_q <= 1'b0;
      o_cnt_q <= '0; o_min_q <= '0; o_max_q <= '0; o_mean_q <= '0;
      o_std_q <= '0; o_bidx_q <= '0; o_btot_q <= '0; o_bst_q <= BIN_NONE;
    end else begin
      if (out_load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE:  scale_q <= cfg_data_i;
          CFG_BINW:   binw_q  <= cfg_data_i[15:0];
          CFG_HALWAY: halw_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        S_CLR: begin
          if (clr_q == AW'(HIST_BINS - 1)) begin
            clr_q <= '0;
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            hist_q <= hist_this_i;
            clr_go_q <= (func_i == FUNC_CLEAR);
            if (func_i == FUNC_CLEAR) begin
              cnt_q <= '0; min_q <= '0; max_q <= '0; sum_q <= '0; sq_q <= '0;
              mean_q <= '0; std_q <= '0; btot_q <= '0; bst_q <= BIN_NONE;
              state_q <= S_OUT;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin : acc
          logic signed [31:0] xs;
          logic [47:0] q;
          q = prod_q[63:16];
          if (neg_q) xs = (q >= 48'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
          else xs = (q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
          x_q <= xs;
          state_q <= S_BDIV;
          bq_q <= xs; br_q <= '0; bc_q <= 6'd32;
          bst_q <= (hist_q || halw_q) ? (xs[31] ? BIN_RANGE : BIN_UPDT) : BIN_NONE;
        end
        S_BDIV: begin
          if (bc_q == 6'd0) begin
            // update scalar accumulators once
            if (cnt_q == 32'd0 || x_q < min_q) min_q <= x_q;
            if (cnt_q == 32'd0 || x_q > max_q) max_q <= x_q;
            if (sum_w > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (sum_w < -65'sh0_8000_0000_0000_0000) sum_q <= 64'sh8000_0000_0000_0000;
            else sum_q <= sum_w[63:0];
            sq_q <= sq_w[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_w[63:0];
            if (cnt_q != 32'hFFFF_FFFF) cnt_q <= cnt_q + 32'd1;
            if (bst_q == BIN_UPDT && bq_q >= 32'(HIST_BINS)) bst_q <= BIN_RANGE;
            bidx_q <= AW'(bq_q);
            state_q <= S_BRD;
          end else begin : bstep
            logic [32:0] t;
            t = {br_q, bq_q[31]};
            bq_q <= {bq_q[30:0], (t >= 33'(w_eff))};
            br_q <= (t >= 33'(w_eff)) ? 32'(t - 33'(w_eff)) : t[31:0];
            bc_q <= bc_q - 6'd1;
          end
        end
        S_BRD: state_q <= S_BWR;
        S_BWR: begin
          btot_q <= (bst_q != BIN_UPDT) ? 32'd0 :
                    (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;
          ds_q <= 1'b0;
          state_q <= S_MDIV;
        end
        S_MDIV: begin
          if (ds_done) begin
            mean_q <= mean_sat; ds_q <= 1'b0; state_q <= S_QDIV;
          end else begin
            ds_q <= 1'b1;
          end
        end
        S_QDIV: begin
          if (ds_done) begin
            ex2_q <= ds_res; ds_q <= 1'b0;
            if (ds_res <= msq) begin
              std_q <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_SQRT;
            end
          end else begin
            ds_q <= 1'b1;
          end
        end
        S_SQRT: begin
          if (ds_done) begin
            std_q <= ds_res[31:0]; ds_q <= 1'b0; state_q <= S_OUT;
          end else begin
            ds_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            o_cnt_q <= cnt_q; o_min_q <= min_q; o_max_q <= max_q; o_mean_q <= mean_q;
            o_std_q <= std_q; o_bst_q <= bst_q; o_btot_q <= btot_q;
            o_bidx_q <= (bst_q == BIN_UPDT) ? 10'(bidx_q) : 10'd0;
            state_q <= clr_go_q ? S_CLR : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = ov_q;
  assign sample_count_o = o_cnt_q;
  assign min_value_o    = o_min_q;
  assign max_value_o    = o_max_q;
  assign mean_value_o   = o_mean_q;
  assign std_dev_o      = o_std_q;
  assign bin_index_o    = o_bidx_q;
  assign bin_total_o    = o_btot_q;
  assign bin_status_o   = o_bst_q;

  logic unused;
  assign unused = ^btrial ^ ctl.busy;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("beat taken while busy");
  a_ds_done_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_done |-> (state_q == S_MDIV || state_q == S_QDIV || state_q == S_SQRT))
    else $error("stray unit done");
  a_bin_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_bst_q != BIN_UPDT) |-> (o_btot_q == 32'd0)) else $error("bin total");
endmodule

// ===== bench/running_stats_histogram_checker.sv =====
// Checker for running_stats_histogram: watches both channels, predicts every
// result beat from its own copy of the statistics state and compares fields.
// Depends on rsh_pkg.
module running_stats_histogram_checker
  import rsh_pkg::*;
#(
  parameter int unsigned HIST_BINS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              func_i,
  input  logic signed [31:0] sample_i,
  input  logic              hist_this_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [31:0]       sample_count_i,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] max_value_i,
  input  logic signed [31:0] mean_value_i,
  input  logic [31:0]       std_dev_i,
  input  logic [9:0]        bin_index_i,
  input  logic [31:0]       bin_total_i,
  input  logic [1:0]        bin_status_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ExpDepth = 16;

  typedef struct packed {
    logic [31:0]        cnt;
    logic signed [31:0] mn;
    logic signed [31:0] mx;
    logic signed [31:0] mean;
    logic [31:0]        sd;
    logic [9:0]         bidx;
    logic [31:0]        btot;
    logic [1:0]         bstat;
  } stats_t;

  logic [31:0]        scale_q;
  logic [15:0]        binw_q;
  logic               hall_q;
  logic [31:0]        cnt_q;
  logic signed [31:0] min_q, max_q;
  logic signed [63:0] sum_q;
  logic [63:0]        sumsq_q;
  logic [31:0]        bins_q [HIST_BINS];
  stats_t             exp_mem [ExpDepth];
  int                 wr_ptr, rd_ptr, exp_fill;
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = exp_fill;

  function automatic logic signed [31:0] scale(logic signed [31:0] raw);
    logic [63:0] mag, q;
    mag = raw[31] ? 64'(-64'(raw)) : 64'(raw);
    q   = (mag * 64'(scale_q)) >> 16;
    if (raw[31]) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
    return (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void clear_all();
    cnt_q = 0; min_q = 0; max_q = 0; sum_q = 0; sumsq_q = 0;
    foreach (bins_q[i]) bins_q[i] = 0;
  endfunction

  function automatic stats_t apply_beat(logic f, logic signed [31:0] raw, logic h);
    stats_t r;
    logic signed [31:0] x;
    logic signed [64:0] s;
    logic [64:0] sq;
    logic [63:0] mag, q, ex2, msq;
    logic [31:0] w, idx;
    r = '0;
    if (f == FUNC_CLEAR) begin
      clear_all();
    end else begin
      x = scale(raw);
      if (cnt_q == 0 || x < min_q) min_q = x;
      if (cnt_q == 0 || x > max_q) max_q = x;
      s = 65'(sum_q) + 65'(x);
      if (s > 65'sh0_7fff_ffff_ffff_ffff) sum_q = 64'sh7fff_ffff_ffff_ffff;
      else if (s < -65'sh0_8000_0000_0000_0000) sum_q = 64'sh8000_0000_0000_0000;
      else sum_q = s[63:0];
      sq = 65'(sumsq_q) + 65'(64'(64'(x) * 64'(x)));
      sumsq_q = sq[64] ? '1 : sq[63:0];
      if (cnt_q != '1) cnt_q++;
      if (h || hall_q) begin
        w = (binw_q == 0) ? 1 : binw_q;
        if (x < 0) begin
          r.bstat = BIN_RANGE;
        end else begin
          idx = 32'(x) / w;
          if (idx >= HIST_BINS) begin
            r.bstat = BIN_RANGE;
          end else begin
            if (bins_q[idx] != '1) bins_q[idx]++;
            r.bstat = BIN_UPDT;
            r.bidx  = idx[9:0];
            r.btot  = bins_q[idx];
          end
        end
      end
    end
    r.cnt = cnt_q; r.mn = min_q; r.mx = max_q;
    if (cnt_q != 0) begin
      mag = sum_q[63] ? -sum_q : sum_q;
      q = mag / 64'(cnt_q);
      if (sum_q[63]) r.mean = (q >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
      else r.mean = (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : 32'(q);
      msq = 64'(64'(r.mean) * 64'(r.mean));
      ex2 = sumsq_q / 64'(cnt_q);
      r.sd = (ex2 <= msq) ? 0 : 32'(floor_sqrt(ex2 - msq));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e, a;
    if (!rst_ni) begin
      scale_q = 32'd65536; binw_q = 1; hall_q = 0;
      clear_all();
      wr_ptr = 0; rd_ptr = 0; exp_fill = 0;
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCALE:  scale_q = cfg_data_i;
          CFG_BINW:   binw_q = cfg_data_i[15:0];
          CFG_HALWAY: hall_q = cfg_data_i[0];
          default: ;
        endcase
      end
      // retire the oldest expected beat before queuing a new one
      if (out_valid_i && !out_stall_i) begin
        a = '{sample_count_i, min_value_i, max_value_i, mean_value_i, std_dev_i,
              bin_index_i, bin_total_i, bin_status_i};
        if (exp_fill == 0) begin
          $display("%t: unexpected result beat %p", $realtime, a);
          fails++;
        end else begin
          e = exp_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % ExpDepth;
          exp_fill--;
          if (e != a) begin
            $display("%t: mismatch expected %p actual %p", $realtime, e, a);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (exp_fill == ExpDepth) begin
          $display("%t: too many result beats outstanding", $realtime);
          fails++;
        end else begin
          exp_mem[wr_ptr] = apply_beat(func_i, sample_i, hist_this_i);
          wr_ptr = (wr_ptr + 1) % ExpDepth;
          exp_fill++;
        end
      end
    end
  end
endmodule

// ===== bench/running_stats_histogram_test.sv =====
// Top of the running_stats_histogram bench: clock, reset, stimulus and verdict.
// Depends on rsh_pkg, the block and running_stats_histogram_checker.
module running_stats_histogram_test;
  import rsh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, func_i = 0, hist_this_i = 0, out_stall_i = 0;
  logic signed [31:0] sample_i = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_idx_i = CFG_SCALE;
  logic [31:0] cfg_data_i = 0;
  logic in_stall_o, out_valid_o;
  logic [31:0] sample_count_o, std_dev_o, bin_total_o;
  logic signed [31:0] min_value_o, max_value_o, mean_value_o;
  logic [9:0] bin_index_o;
  logic [1:0] bin_status_o;
  int fail_count, pending;
  int send_idle, recv_idle;

  always #5 clk_i = ~clk_i;

  running_stats_histogram dut (.*);

  running_stats_histogram_checker chk (
    .in_stall_i(in_stall_o), .out_valid_i(out_valid_o),
    .sample_count_i(sample_count_o), .min_value_i(min_value_o),
    .max_value_i(max_value_o), .mean_value_i(mean_value_o),
    .std_dev_i(std_dev_o), .bin_index_i(bin_index_o), .bin_total_i(bin_total_o),
    .bin_status_i(bin_status_o), .fail_count_o(fail_count), .pending_o(pending),
    .*);

  // Receiver stall, redrawn every cycle.
  always @(posedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle);

  task automatic send_beat(logic f, logic signed [31:0] s, logic h);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1;
    func_i      <= f;
    sample_i    <= s;
    hist_this_i <= h;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // Let a clear sweep finish before touching registers.
    repeat (1200) @(posedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 3000);
      2: return -$signed($urandom_range(0, 500));
      3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom_range(0, 1100);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_beat(($urandom_range(39) == 0) ? FUNC_CLEAR : FUNC_ADD, pick_sample(),
                $urandom_range(1));
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: extremes, clears, bin edges.
    send_beat(FUNC_ADD, 0, 1);
    send_beat(FUNC_ADD, 32'sh7fff_ffff, 1);
    send_beat(FUNC_ADD, 32'sh8000_0000, 1);
    send_beat(FUNC_ADD, -1, 1);
    send_beat(FUNC_ADD, 1023, 1);
    send_beat(FUNC_ADD, 1024, 1);
    send_beat(FUNC_ADD, 5, 0);
    send_beat(FUNC_ADD, 5, 1);
    send_beat(FUNC_CLEAR, 32'shffff_ffff, 1);
    send_beat(FUNC_ADD, 7, 1);
    write_reg(CFG_SCALE, 32'hffff_ffff);
    write_reg(CFG_BINW, 0);
    write_reg(CFG_HALWAY, 1);
    send_beat(FUNC_ADD, 32'sh7fff_ffff, 0);
    send_beat(FUNC_ADD, 32'sh8000_0000, 0);
    send_beat(FUNC_ADD, 3, 0);
    send_beat(FUNC_ADD, -3, 0);
    // Drive sum toward saturation: many big values.
    repeat (6) send_beat(FUNC_ADD, 32'sh7fff_ffff, 0);
    write_reg(CFG_SCALE, 0);
    send_beat(FUNC_ADD, 1234, 0);
    send_beat(FUNC_CLEAR, 0, 0);

    write_reg(CFG_SCALE, 32'd65536);
    write_reg(CFG_BINW, 16'hffff);
    write_reg(CFG_HALWAY, 0);
    send_idle = 38; recv_idle = 61;
    random_phase(500);
    write_reg(CFG_SCALE, 32'h0000_8000);
    write_reg(CFG_BINW, 3);
    write_reg(CFG_HALWAY, 1);
    send_idle = 61; recv_idle = 38;
    random_phase(500);
    write_reg(CFG_SCALE, $urandom);
    write_reg(CFG_BINW, 1);
    send_idle = 0; recv_idle = 0;
    random_phase(520);

    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
